>>> src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SKMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define SKMF_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define SKMF_ASSERT(lbl, clk, rst_n, prop)

`define SKMF_ASSERT_MSG(lbl, clk, rst_n, prop, msg)

`endif

`endif

>>> src/skmf_pkg.sv
package skmf_pkg;

    localparam int CHAN_W           = 8;
    localparam int CFG_W            = 8;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 5;
    localparam int MAX_FRAME_PIXELS = 4194304;
    localparam int CNT_W            = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int TOTAL_W          = 23;

    typedef enum logic [2:0] {
        REG_LUMA_THR = 3'd0,
        REG_CR_LOWER = 3'd1,
        REG_CR_UPPER = 3'd2,
        REG_CB_LOWER = 3'd3,
        REG_CB_UPPER = 3'd4
    } reg_idx_t;

    localparam logic [CFG_W-1:0] LUMA_THR_RST = 8'd110;
    localparam logic [CFG_W-1:0] CR_LOWER_RST = 8'd80;
    localparam logic [CFG_W-1:0] CR_UPPER_RST = 8'd130;
    localparam logic [CFG_W-1:0] CB_LOWER_RST = 8'd145;
    localparam logic [CFG_W-1:0] CB_UPPER_RST = 8'd180;

    typedef struct packed {
        logic [CFG_W-1:0] luma_threshold;
        logic [CFG_W-1:0] cr_lower;
        logic [CFG_W-1:0] cr_upper;
        logic [CFG_W-1:0] cb_lower;
        logic [CFG_W-1:0] cb_upper;
    } skmf_cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_first;
        logic [CHAN_W-1:0] chan_second;
        logic [CHAN_W-1:0] chan_third;
        logic              frame_last;
    } skmf_pix_t;

endpackage

>>> src/skmf_if.sv
interface skmf_pix_if;
    logic                         valid;
    logic                         ready;
    logic [skmf_pkg::CHAN_W-1:0]  chan_first;
    logic [skmf_pkg::CHAN_W-1:0]  chan_second;
    logic [skmf_pkg::CHAN_W-1:0]  chan_third;
    logic                         frame_last;

    modport source (
        output valid, chan_first, chan_second, chan_third, frame_last,
        input  ready
    );
    modport sink (
        input  valid, chan_first, chan_second, chan_third, frame_last,
        output ready
    );
endinterface

interface skmf_res_if;
    logic                         valid;
    logic                         ready;
    logic                         skin_pixel;
    logic                         frame_end;
    logic                         face_found;
    logic [skmf_pkg::TOTAL_W-1:0] skin_total;

    modport source (
        output valid, skin_pixel, frame_end, face_found, skin_total,
        input  ready
    );
    modport sink (
        input  valid, skin_pixel, frame_end, face_found, skin_total,
        output ready
    );
endinterface

>>> src/skmf_regs.sv
module skmf_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [skmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [skmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [skmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output skmf_pkg::skmf_cfg_t                 cfg
);
    import skmf_pkg::*;

    skmf_cfg_t        cfg_reg;
    skmf_cfg_t        cfg_next;
    logic             wr_en;
    reg_idx_t         idx;
    logic [CFG_W-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LUMA_THR: cfg_next.luma_threshold = pwdata[CFG_W-1:0];
                REG_CR_LOWER: cfg_next.cr_lower       = pwdata[CFG_W-1:0];
                REG_CR_UPPER: cfg_next.cr_upper       = pwdata[CFG_W-1:0];
                REG_CB_LOWER: cfg_next.cb_lower       = pwdata[CFG_W-1:0];
                REG_CB_UPPER: cfg_next.cb_upper       = pwdata[CFG_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LUMA_THR: rd_val = cfg_reg.luma_threshold;
            REG_CR_LOWER: rd_val = cfg_reg.cr_lower;
            REG_CR_UPPER: rd_val = cfg_reg.cr_upper;
            REG_CB_LOWER: rd_val = cfg_reg.cb_lower;
            REG_CB_UPPER: rd_val = cfg_reg.cb_upper;
            default:      rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_threshold <= LUMA_THR_RST;
            cfg_reg.cr_lower       <= CR_LOWER_RST;
            cfg_reg.cr_upper       <= CR_UPPER_RST;
            cfg_reg.cb_lower       <= CB_LOWER_RST;
            cfg_reg.cb_upper       <= CB_UPPER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/skmf_classify.sv
module skmf_classify (
    input  skmf_pkg::skmf_pix_t pix,
    input  skmf_pkg::skmf_cfg_t cfg,
    output logic                skin
);
    import skmf_pkg::*;

    localparam int NUM_W = 12;

    // ten times a bound, compared against the undivided numerator
    function automatic logic [NUM_W-1:0] times_ten(input logic [CFG_W:0] v);
        times_ten = NUM_W'(v) * NUM_W'(10);
    endfunction

    logic [NUM_W-1:0] a;
    logic [NUM_W-1:0] b;
    logic [NUM_W-1:0] c;
    logic [NUM_W-1:0] y_num;
    logic [NUM_W-1:0] cr_num;
    logic [NUM_W-1:0] cb_num;
    logic             y_ok;
    logic             cr_ok;
    logic             cb_ok;

    assign a = NUM_W'(pix.chan_first);
    assign b = NUM_W'(pix.chan_second);
    assign c = NUM_W'(pix.chan_third);

    // numerators stay in 0..2555, so modulo arithmetic is exact
    assign y_num  = NUM_W'(3) * a + NUM_W'(6) * b + c;
    assign cr_num = NUM_W'(1280) + NUM_W'(5) * a - NUM_W'(4) * b - c;
    assign cb_num = NUM_W'(1280) + NUM_W'(5) * c - NUM_W'(2) * a - NUM_W'(3) * b;

    // floor(n/10) > t  <=>  n >= 10(t+1);  floor(n/10) < t  <=>  n < 10t
    assign y_ok  = y_num >= times_ten({1'b0, cfg.luma_threshold} + 1'b1);
    assign cr_ok = (cr_num >= times_ten({1'b0, cfg.cr_lower} + 1'b1))
                && (cr_num <  times_ten({1'b0, cfg.cr_upper}));
    assign cb_ok = (cb_num >= times_ten({1'b0, cfg.cb_lower} + 1'b1))
                && (cb_num <  times_ten({1'b0, cfg.cb_upper}));

    assign skin = y_ok && cr_ok && cb_ok;

endmodule

>>> src/skmf_frame_acc.sv
module skmf_frame_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              skin,
    input  logic              last,
    output logic              take,
    skmf_res_if.source        res
);
    import skmf_pkg::*;

    `include "assert_macros.svh"

    localparam int FACE_W = CNT_W + 4;

    logic [CNT_W-1:0]   pix_cnt_reg;
    logic [CNT_W-1:0]   pix_cnt_next;
    logic [CNT_W-1:0]   skin_cnt_reg;
    logic [CNT_W-1:0]   skin_cnt_next;
    logic [CNT_W-1:0]   pix_inc;
    logic [CNT_W-1:0]   skin_inc;
    logic [FACE_W-1:0]  skin_x10;
    logic               face;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic               skin_pixel_reg;
    logic               frame_end_reg;
    logic               face_found_reg;
    logic [TOTAL_W-1:0] skin_total_reg;

    assign take = in_valid && (!res_valid_reg || res.ready);

    // saturating counts with this transaction included
    assign pix_inc  = (pix_cnt_reg < CNT_W'(MAX_FRAME_PIXELS))
                    ? pix_cnt_reg + 1'b1 : pix_cnt_reg;
    assign skin_inc = (skin && (skin_cnt_reg < CNT_W'(MAX_FRAME_PIXELS)))
                    ? skin_cnt_reg + 1'b1 : skin_cnt_reg;
    assign skin_x10 = FACE_W'(skin_inc) * FACE_W'(10);
    assign face     = last && (skin_x10 >= FACE_W'(pix_inc));

    always_comb
    begin
        pix_cnt_next  = pix_cnt_reg;
        skin_cnt_next = skin_cnt_reg;
        if (take)
        begin
            pix_cnt_next  = last ? '0 : pix_inc;
            skin_cnt_next = last ? '0 : skin_inc;
        end
    end

    always_comb
    begin
        if (take)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg   <= '0;
            skin_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pix_cnt_reg   <= pix_cnt_next;
            skin_cnt_reg  <= skin_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            skin_pixel_reg <= skin;
            frame_end_reg  <= last;
            face_found_reg <= face;
            skin_total_reg <= TOTAL_W'(skin_inc);
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.skin_pixel = skin_pixel_reg;
    assign res.frame_end  = frame_end_reg;
    assign res.face_found = face_found_reg;
    assign res.skin_total = skin_total_reg;

    `SKMF_ASSERT(a_pix_cnt_sat, clk, rst_n, pix_cnt_reg <= CNT_W'(MAX_FRAME_PIXELS))
    `SKMF_ASSERT(a_skin_le_pix, clk, rst_n, skin_cnt_reg <= pix_cnt_reg)
    `SKMF_ASSERT_MSG(a_frame_clear, clk, rst_n, (take && last) |=> (pix_cnt_reg == '0 && skin_cnt_reg == '0), "counters not cleared at frame end")
    `SKMF_ASSERT_MSG(a_face_at_end, clk, rst_n, (res_valid_reg && face_found_reg) |-> frame_end_reg, "face flag outside frame end")

endmodule

>>> src/skin_mask_face_presence_unit.sv
// channel  dir  protocol      payload
// pix      in   valid/ready   chan_first, chan_second, chan_third, frame_last
// res      out  valid/ready   skin_pixel, frame_end, face_found, skin_total
// apb      in   apb write/rd  five 8-bit threshold registers at 4*index
//
// one pixel per clock sustained while res.ready holds; the result register follows the input register
// input register, then classify and count logic, then result register
// a stalled result keeps one more pixel in the input register
// rst_n clears control, counters and thresholds to defaults; no clearing pass
module skin_mask_face_presence_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [skmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [skmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [skmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    skmf_pix_if.sink                            pix,
    skmf_res_if.source                          res
);
    import skmf_pkg::*;

    skmf_cfg_t cfg;
    skmf_pix_t pix_reg;
    logic      pix_valid_reg;
    logic      pix_valid_next;
    logic      take;
    logic      skin;
    logic      accept;

    skmf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pix.ready      = !pix_valid_reg || take;
    assign accept         = pix.valid && pix.ready;
    assign pix_valid_next = pix.ready ? pix.valid : pix_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg.chan_first  <= pix.chan_first;
            pix_reg.chan_second <= pix.chan_second;
            pix_reg.chan_third  <= pix.chan_third;
            pix_reg.frame_last  <= pix.frame_last;
        end
    end

    skmf_classify u_classify (
        .pix  (pix_reg),
        .cfg  (cfg),
        .skin (skin)
    );

    skmf_frame_acc u_frame_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_valid_reg),
        .skin     (skin),
        .last     (pix_reg.frame_last),
        .take     (take),
        .res      (res)
    );

endmodule
